// ----- sv/ppm_pkg.sv -----
// Shared constants, types and helper functions of the peak program meter.
package ppm_pkg;

	// Sizes
	localparam int CHANNELS    = 8;
	localparam int SAMPLE_BITS = 24;
	localparam int FRAC_BITS   = 16;
	localparam int COEF_BITS   = 24;
	localparam int CH_W        = 3;
	localparam int OUT_W       = 23;
	localparam int MAG_W       = SAMPLE_BITS - 1;
	localparam int ENV_W       = SAMPLE_BITS + FRAC_BITS;
	localparam int ENVH_W      = (ENV_W > COEF_BITS) ? (ENV_W - COEF_BITS) : 1;
	localparam int D_W         = COEF_BITS + ENVH_W;
	localparam int PHI_W       = COEF_BITS + ENVH_W;
	localparam int PLO_W       = 2 * COEF_BITS;
	localparam int CH_AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ENTRY_W     = ENV_W + 2 * MAG_W;

	// Configuration port
	localparam int ADDR_W        = 3;
	localparam int DATA_W        = 32;
	localparam int ATTACK_RESET  = 83488;
	localparam int RELEASE_RESET = 558;

	typedef enum logic [0:0] {
		REG_ATTACK  = 1'b0,
		REG_RELEASE = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [COEF_BITS-1:0] attack;
		logic [COEF_BITS-1:0] release_c;
	} coef_cfg_t;

	// One channel's state as kept in memory
	typedef struct packed {
		logic [ENV_W-1:0] env;
		logic [MAG_W-1:0] bmax;
		logic [MAG_W-1:0] held;
	} entry_t;

	// Magnitude of a two's complement sample, saturated at the largest positive value
	function automatic logic [MAG_W-1:0] magnitude(input logic [SAMPLE_BITS-1:0] v);
		logic [SAMPLE_BITS-1:0] m;
		m = v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
		if (m[SAMPLE_BITS-1])
			return '1;
		return m[MAG_W-1:0];
	endfunction

endpackage

// ----- sv/ppm_if.sv -----
// Stream interfaces for sample items and meter result items.
interface ppm_in_if;
	import ppm_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [CH_W-1:0]        channel;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   block_end;

	modport source (output valid, output channel, output sample, output block_end,
		input ready);
	modport sink (input valid, input channel, input sample, input block_end,
		output ready);
endinterface

interface ppm_out_if;
	import ppm_pkg::*;

	logic             valid;
	logic             ready;
	logic [CH_W-1:0]  out_channel;
	logic [OUT_W-1:0] envelope;
	logic [OUT_W-1:0] block_peak;
	logic [OUT_W-1:0] held_peak;
	logic             peak_ready;

	modport source (output valid, output out_channel, output envelope, output block_peak,
		output held_peak, output peak_ready, input ready);
	modport sink (input valid, input out_channel, input envelope, input block_peak,
		input held_peak, input peak_ready, output ready);
endinterface

// ----- sv/ppm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ppm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	// Registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem_q[raddr];
	end
endmodule

// ----- sv/ppm_apb_regs.sv -----
// APB-style configuration registers holding the attack and release coefficients.
module ppm_apb_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ppm_pkg::ADDR_W-1:0]   paddr,
	input  logic [ppm_pkg::DATA_W-1:0]   pwdata,
	output logic [ppm_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output ppm_pkg::coef_cfg_t           cfg
);
	import ppm_pkg::*;

	coef_cfg_t cfg_q;
	reg_idx_t  idx;
	logic      wr_en;

	assign idx    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Write the addressed coefficient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack    <= COEF_BITS'(ATTACK_RESET);
			cfg_q.release_c <= COEF_BITS'(RELEASE_RESET);
		end else if (wr_en) begin
			case (idx)
				REG_ATTACK:  cfg_q.attack    <= pwdata[COEF_BITS-1:0];
				REG_RELEASE: cfg_q.release_c <= pwdata[COEF_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed coefficient
	always_comb begin
		case (idx)
			REG_ATTACK:  prdata = DATA_W'(cfg_q.attack);
			REG_RELEASE: prdata = DATA_W'(cfg_q.release_c);
			default:     prdata = '0;
		endcase
	end
endmodule

// ----- sv/ppm_core.sv -----
// Envelope pipeline: channel state read, coefficient multiply, update and write back.
module ppm_core (
	input  logic               clk,
	input  logic               arst_n,
	input  ppm_pkg::coef_cfg_t cfg,
	ppm_in_if.sink             samples,
	ppm_out_if.source          results
);
	import ppm_pkg::*;

	// Handshake and hazard control
	logic accept, out_free, en1, en2, hazard, load_out;
	logic in_range_in;

	// Stage 1
	logic             valid_s1, inr_s1, end_s1, byp_s1, vld_s1;
	logic [CH_W-1:0]  ch_s1;
	logic [MAG_W-1:0] mag_s1;
	entry_t           bypd_s1;

	// Stage 2
	logic             valid_s2, inr_s2, end_s2, rel_s2;
	logic [CH_W-1:0]  ch_s2;
	entry_t           ent_s2;
	logic [PHI_W-1:0] phi_s2;
	logic [PLO_W-1:0] plo_s2;

	// Output register
	logic             out_v_q, out_pr_q;
	logic [CH_W-1:0]  out_ch_q;
	logic [OUT_W-1:0] out_env_q, out_bpk_q, out_held_q;

	// Memory and entry valid bits
	logic [CHANNELS-1:0] valid_q;
	logic [ENTRY_W-1:0]  rdata;
	logic                we;
	entry_t              wr_ent;

	// Stage 1 datapath
	entry_t               ent1;
	logic [ENV_W-1:0]     big1, d1;
	logic [D_W-1:0]       d1_ext;
	logic [COEF_BITS-1:0] c1;
	logic                 rel1;

	// Stage 2 datapath
	logic [PHI_W-1:0] q2;
	logic             frac_nz2;
	logic [ENV_W-1:0] env2;
	logic [MAG_W-1:0] ipart2, bmax2, held2;

	assign in_range_in = 32'(samples.channel) < CHANNELS;

	// Advance a stage when the next one is empty or moves on
	assign out_free = !out_v_q || results.ready;
	assign en2      = !valid_s2 || out_free;
	assign en1      = !valid_s1 || en2;
	// Hold an item whose channel still has an update in stage 1, or a stalled one in stage 2
	assign hazard   = (valid_s1 && ch_s1 == samples.channel) ||
		(valid_s2 && !en2 && ch_s2 == samples.channel);
	assign samples.ready = en1 && !hazard;
	assign accept   = samples.valid && samples.ready;
	assign load_out = valid_s2 && out_free;

	ppm_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CHANNELS)
	) u_state_ram (
		.clk   (clk),
		.we    (we),
		.waddr (CH_AW'(ch_s2)),
		.wdata (wr_ent),
		.re    (accept),
		.raddr (CH_AW'(samples.channel)),
		.rdata (rdata)
	);

	// Stage 1: pick the current entry, choose attack or release, multiply
	always_comb begin
		if (byp_s1)
			ent1 = bypd_s1;
		else if (vld_s1)
			ent1 = entry_t'(rdata);
		else
			ent1 = '0;
		big1   = ENV_W'({mag_s1, {FRAC_BITS{1'b0}}});
		rel1   = ent1.env > big1;
		c1     = rel1 ? cfg.release_c : cfg.attack;
		d1     = rel1 ? ent1.env : (big1 - ent1.env);
		d1_ext = D_W'(d1);
	end

	// Stage 2: combine partial products, update envelope and peaks
	always_comb begin
		q2       = phi_s2 + PHI_W'(plo_s2[PLO_W-1:COEF_BITS]);
		frac_nz2 = |plo_s2[COEF_BITS-1:0];
		if (rel_s2)
			env2 = ent_s2.env - ENV_W'(q2) - ENV_W'(frac_nz2);
		else
			env2 = ent_s2.env + ENV_W'(q2);
		// The envelope never exceeds the largest magnitude, so its top bit stays clear
		ipart2 = env2[FRAC_BITS+MAG_W-1:FRAC_BITS];
		bmax2  = (ipart2 > ent_s2.bmax) ? ipart2 : ent_s2.bmax;
		held2  = end_s2 ? bmax2 : ent_s2.held;
		wr_ent.env  = env2;
		wr_ent.bmax = end_s2 ? '0 : bmax2;
		wr_ent.held = held2;
	end

	assign we = valid_s2 && inr_s2 && en2;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_v_q  <= 1'b0;
			valid_q  <= '0;
		end else begin
			if (en1)
				valid_s1 <= accept;
			if (en2)
				valid_s2 <= valid_s1;
			if (load_out)
				out_v_q <= 1'b1;
			else if (results.ready)
				out_v_q <= 1'b0;
			if (we)
				valid_q[CH_AW'(ch_s2)] <= 1'b1;
		end
	end

	// Stage 1 payload, with forwarding of the entry written at the same edge
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1   <= samples.channel;
			inr_s1  <= in_range_in;
			end_s1  <= samples.block_end;
			mag_s1  <= magnitude(samples.sample);
			byp_s1  <= we && ch_s2 == samples.channel;
			bypd_s1 <= wr_ent;
			vld_s1  <= valid_q[CH_AW'(samples.channel)];
		end
	end

	// Stage 2 payload
	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			ch_s2  <= ch_s1;
			inr_s2 <= inr_s1;
			end_s2 <= end_s1;
			rel_s2 <= rel1;
			ent_s2 <= ent1;
			phi_s2 <= c1 * d1_ext[D_W-1:COEF_BITS];
			plo_s2 <= c1 * d1_ext[COEF_BITS-1:0];
		end
	end

	// Output payload; out-of-range channels report zeros
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_ch_q <= ch_s2;
			if (inr_s2) begin
				out_env_q  <= OUT_W'(ipart2);
				out_bpk_q  <= OUT_W'(bmax2);
				out_held_q <= OUT_W'(held2);
				out_pr_q   <= end_s2;
			end else begin
				out_env_q  <= '0;
				out_bpk_q  <= '0;
				out_held_q <= '0;
				out_pr_q   <= 1'b0;
			end
		end
	end

	assign results.valid       = out_v_q;
	assign results.out_channel = out_ch_q;
	assign results.envelope    = out_env_q;
	assign results.block_peak  = out_bpk_q;
	assign results.held_peak   = out_held_q;
	assign results.peak_ready  = out_pr_q;
endmodule

// ----- sv/peak_program_meter.sv -----
// Top level of the per-channel peak program meter.
//
//  port      dir  handshake        carries
//  samples   in   valid/ready      channel, sample, block_end
//  results   out  valid/ready      out_channel, envelope, block_peak, held_peak, peak_ready
//  apb       in   psel/penable     attack_coeff at 0x0, release_coeff at 0x4
//
// An item is accepted every cycle when consecutive items use different channels and
// the output is not stalled; two items of the same channel are kept apart by the
// read-modify-write loop through the state memory (write data forwarded into the
// following read). An accepted item passes stage 1, stage 2 and the output register
// to result valid; a result stalled at the output lets up to two more items enter.
// Reset clears per-channel valid bits, so every channel reads as zero at once with no clearing pass.
module peak_program_meter (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ppm_pkg::ADDR_W-1:0] paddr,
	input  logic [ppm_pkg::DATA_W-1:0] pwdata,
	output logic [ppm_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	ppm_in_if.sink                     samples,
	ppm_out_if.source                  results
);
	import ppm_pkg::*;

	coef_cfg_t cfg;

	ppm_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ppm_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.samples (samples),
		.results (results)
	);
endmodule
